/* hw/rtl/bpab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpab_pkg
// Shared types and constants of the bilinear pixel alpha blend pipeline.
// ----------------------------------------------------------------------------
package bpab_pkg;

   localparam int FRAC_BITS_DEF = 7;
   localparam int BYTE_W        = 8;
   localparam int FRAC_IN_W     = 8;
   localparam int NUM_CH        = 3;
   localparam int NUM_LANES     = NUM_CH + 1;
   localparam int ALPHA_LANE    = NUM_CH;
   localparam int MRG_W         = 2 * BYTE_W + 2;

   // lanes 0..2 carry the color channels, lane 3 the alpha byte
   typedef logic [NUM_LANES-1:0][BYTE_W-1:0] lane_bytes_type;
   typedef logic [NUM_CH-1:0][BYTE_W-1:0]    dest_bytes_type;

endpackage
`default_nettype wire

/* hw/rtl/bpab_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpab_if
// Valid/ready channels for the pixel request and the blended response.
// ----------------------------------------------------------------------------
interface bpab_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] top_left_rgb;
   logic [23:0] top_right_rgb;
   logic [23:0] bottom_left_rgb;
   logic [23:0] bottom_right_rgb;
   logic [31:0] alpha_quad;
   logic [7:0]  frac_x;
   logic [7:0]  frac_y;
   logic        right_valid;
   logic        below_valid;
   logic [23:0] dest_rgb;

   modport source (
      output valid, top_left_rgb, top_right_rgb, bottom_left_rgb, bottom_right_rgb,
             alpha_quad, frac_x, frac_y, right_valid, below_valid, dest_rgb,
      input  ready
   );
   modport sink (
      input  valid, top_left_rgb, top_right_rgb, bottom_left_rgb, bottom_right_rgb,
             alpha_quad, frac_x, frac_y, right_valid, below_valid, dest_rgb,
      output ready
   );
endinterface

interface bpab_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_channel_one;
   logic [7:0] out_channel_two;
   logic [7:0] out_channel_three;
   logic [7:0] blend_alpha;

   modport source (
      output valid, out_channel_one, out_channel_two, out_channel_three, blend_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_channel_one, out_channel_two, out_channel_three, blend_alpha,
      output ready
   );
endinterface
`default_nettype wire

/* hw/rtl/bpab_prep.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpab_prep
// Input stage: clamp the fractions, replace absent neighbors, split lanes.
// ----------------------------------------------------------------------------
module bpab_prep
   import bpab_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   bpab_req_if.sink              req_chan,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      lane_bytes_type   out_near0,
   output      lane_bytes_type   out_next0,
   output      lane_bytes_type   out_near1,
   output      lane_bytes_type   out_next1,
   output      logic [FRAC_BITS:0] out_fx,
   output      logic [FRAC_BITS:0] out_fy,
   output      dest_bytes_type   out_dest
);

   localparam int FW = FRAC_BITS + 1;
   localparam int CW = (FW > FRAC_IN_W) ? FW : FRAC_IN_W;
   localparam logic [CW-1:0] ONE_CW = CW'(1) << FRAC_BITS;

   logic           valid_ff, valid_in;
   lane_bytes_type tl, tr, bl, br;
   lane_bytes_type near0_ff, next0_ff, near1_ff, next1_ff;
   lane_bytes_type near0_in, next0_in, near1_in, next1_in;
   logic [CW-1:0]  fx_wide, fy_wide;
   logic [FW-1:0]  fx_ff, fy_ff, fx_in, fy_in;
   dest_bytes_type dest_ff, dest_in;
   logic           load;

   assign req_chan.ready = !valid_ff || out_ready;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      tl = lane_bytes_type'({req_chan.alpha_quad[7:0],   req_chan.top_left_rgb});
      tr = lane_bytes_type'({req_chan.alpha_quad[15:8],  req_chan.top_right_rgb});
      bl = lane_bytes_type'({req_chan.alpha_quad[23:16], req_chan.bottom_left_rgb});
      br = lane_bytes_type'({req_chan.alpha_quad[31:24], req_chan.bottom_right_rgb});

      near0_in = tl;
      next0_in = req_chan.right_valid ? tr : tl;
      near1_in = req_chan.below_valid ? bl : tl;
      if (req_chan.right_valid) begin
         next1_in = req_chan.below_valid ? br : tr;
      end else begin
         next1_in = req_chan.below_valid ? bl : tl;
      end

      // clamp weights above one
      fx_wide = CW'(req_chan.frac_x);
      fy_wide = CW'(req_chan.frac_y);
      if (fx_wide > ONE_CW) begin
         fx_wide = ONE_CW;
      end
      if (fy_wide > ONE_CW) begin
         fy_wide = ONE_CW;
      end
      fx_in   = fx_wide[FW-1:0];
      fy_in   = fy_wide[FW-1:0];
      dest_in = dest_bytes_type'(req_chan.dest_rgb);

      valid_in = req_chan.ready ? req_chan.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         near0_ff <= near0_in;
         next0_ff <= next0_in;
         near1_ff <= near1_in;
         next1_ff <= next1_in;
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
         dest_ff  <= dest_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_near0 = near0_ff;
   assign out_next0 = next0_ff;
   assign out_near1 = near1_ff;
   assign out_next1 = next1_ff;
   assign out_fx    = fx_ff;
   assign out_fy    = fy_ff;
   assign out_dest  = dest_ff;

endmodule
`default_nettype wire

/* hw/rtl/bpab_hlerp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpab_hlerp
// Horizontal stage: near << F plus weight times step, for both rows and lanes.
// ----------------------------------------------------------------------------
module bpab_hlerp
   import bpab_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output      logic                                    in_ready,
   input  wire lane_bytes_type                          in_near0,
   input  wire lane_bytes_type                          in_next0,
   input  wire lane_bytes_type                          in_near1,
   input  wire lane_bytes_type                          in_next1,
   input  wire logic [FRAC_BITS:0]                      in_fx,
   input  wire logic [FRAC_BITS:0]                      in_fy,
   input  wire dest_bytes_type                          in_dest,
   output      logic                                    out_valid,
   input  wire logic                                    out_ready,
   output      logic [NUM_LANES-1:0][FRAC_BITS+BYTE_W-1:0] out_row0,
   output      logic [NUM_LANES-1:0][FRAC_BITS+BYTE_W-1:0] out_row1,
   output      logic [FRAC_BITS:0]                      out_fy,
   output      dest_bytes_type                          out_dest
);

   localparam int FW = FRAC_BITS + 1;
   localparam int HW = FRAC_BITS + BYTE_W;
   localparam int PW = FRAC_BITS + BYTE_W + 3;

   logic                             valid_ff, valid_in;
   logic [NUM_LANES-1:0][HW-1:0]     row0_ff, row1_ff, row0_in, row1_in;
   logic [FW-1:0]                    fy_ff;
   dest_bytes_type                   dest_ff;
   logic signed [FW:0]               fs;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      fs = signed'({1'b0, in_fx});
      for (int l = 0; l < NUM_LANES; l++) begin
         logic signed [BYTE_W:0] d0, d1;
         logic signed [PW-1:0]   s0, s1;
         d0 = signed'({1'b0, in_next0[l]}) - signed'({1'b0, in_near0[l]});
         d1 = signed'({1'b0, in_next1[l]}) - signed'({1'b0, in_near1[l]});
         s0 = PW'(d0) * PW'(fs) + signed'(PW'({in_near0[l], {FRAC_BITS{1'b0}}}));
         s1 = PW'(d1) * PW'(fs) + signed'(PW'({in_near1[l], {FRAC_BITS{1'b0}}}));
         row0_in[l] = s0[HW-1:0];
         row1_in[l] = s1[HW-1:0];
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         row0_ff <= row0_in;
         row1_ff <= row1_in;
         fy_ff   <= in_fy;
         dest_ff <= in_dest;
      end
   end

   assign out_valid = valid_ff;
   assign out_row0  = row0_ff;
   assign out_row1  = row1_ff;
   assign out_fy    = fy_ff;
   assign out_dest  = dest_ff;

endmodule
`default_nettype wire

/* hw/rtl/bpab_vlerp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpab_vlerp
// Vertical stage: combine the two row values and scale down to a byte.
// ----------------------------------------------------------------------------
module bpab_vlerp
   import bpab_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output      logic                                    in_ready,
   input  wire logic [NUM_LANES-1:0][FRAC_BITS+BYTE_W-1:0] in_row0,
   input  wire logic [NUM_LANES-1:0][FRAC_BITS+BYTE_W-1:0] in_row1,
   input  wire logic [FRAC_BITS:0]                      in_fy,
   input  wire dest_bytes_type                          in_dest,
   output      logic                                    out_valid,
   input  wire logic                                    out_ready,
   output      lane_bytes_type                          out_src,
   output      dest_bytes_type                          out_dest
);

   localparam int FW = FRAC_BITS + 1;
   localparam int HW = FRAC_BITS + BYTE_W;
   localparam int PW = FRAC_BITS + BYTE_W + 3;

   logic               valid_ff, valid_in;
   lane_bytes_type     src_ff, src_in;
   dest_bytes_type     dest_ff;
   logic signed [FW:0] fs;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      fs = signed'({1'b0, in_fy});
      for (int l = 0; l < NUM_LANES; l++) begin
         logic signed [BYTE_W:0] d;
         logic signed [PW-1:0]   s;
         d = signed'({1'b0, in_row1[l][HW-1:FRAC_BITS]})
           - signed'({1'b0, in_row0[l][HW-1:FRAC_BITS]});
         s = PW'(d) * PW'(fs) + signed'(PW'(in_row0[l]));
         src_in[l] = s[HW-1:FRAC_BITS];
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         src_ff  <= src_in;
         dest_ff <= in_dest;
      end
   end

   assign out_valid = valid_ff;
   assign out_src   = src_ff;
   assign out_dest  = dest_ff;

endmodule
`default_nettype wire

/* hw/rtl/bpab_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpab_merge
// Output stage: merge each source byte into the destination byte by alpha.
// ----------------------------------------------------------------------------
module bpab_merge
   import bpab_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_ready,
   input  wire lane_bytes_type in_src,
   input  wire dest_bytes_type in_dest,
   bpab_rsp_if.source          rsp_chan
);

   logic                valid_ff, valid_in;
   dest_bytes_type      pix_ff, pix_in;
   logic [BYTE_W-1:0]   alpha_ff;
   logic signed [BYTE_W:0] av;

   assign in_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      av = signed'({1'b0, in_src[ALPHA_LANE]});
      for (int c = 0; c < NUM_CH; c++) begin
         logic signed [BYTE_W:0]  diff;
         logic signed [MRG_W-1:0] v;
         diff = signed'({1'b0, in_dest[c]}) - signed'({1'b0, in_src[c]});
         v = MRG_W'(diff) * MRG_W'(av) + signed'(MRG_W'({in_src[c], in_dest[c]}));
         pix_in[c] = v[2*BYTE_W-1:BYTE_W];
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pix_ff   <= pix_in;
         alpha_ff <= in_src[ALPHA_LANE];
      end
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.out_channel_one   = pix_ff[0];
   assign rsp_chan.out_channel_two   = pix_ff[1];
   assign rsp_chan.out_channel_three = pix_ff[2];
   assign rsp_chan.blend_alpha       = alpha_ff;

endmodule
`default_nettype wire

/* hw/rtl/bilinear_pixel_alpha_blend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_pixel_alpha_blend
// Bilinear sample of a three-channel source with alpha, merged into a pixel.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one blended word per clock while
// rsp_chan is ready. An accepted word reaches rsp_chan through four register
// stages: input select and weight clamp, horizontal interpolation, vertical
// interpolation, alpha merge. Each stage holds one word with its own valid
// bit; a stalled rsp_chan holds the pipeline and empty stages still fill, so
// up to four words are in flight. The weights are in steps of 1/2^FRAC_BITS
// and are clamped to one; blend_alpha is a transparency, zero giving the
// source color.
module bilinear_pixel_alpha_blend
   import bpab_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bpab_req_if.sink   req_chan,
   bpab_rsp_if.source rsp_chan
);

   localparam int HW = FRAC_BITS + BYTE_W;

   logic                         p_valid, p_ready;
   lane_bytes_type               p_near0, p_next0, p_near1, p_next1;
   logic [FRAC_BITS:0]           p_fx, p_fy;
   dest_bytes_type               p_dest;

   logic                         h_valid, h_ready;
   logic [NUM_LANES-1:0][HW-1:0] h_row0, h_row1;
   logic [FRAC_BITS:0]           h_fy;
   dest_bytes_type               h_dest;

   logic                         v_valid, v_ready;
   lane_bytes_type               v_src;
   dest_bytes_type               v_dest;

   bpab_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_near0 (p_near0),
      .out_next0 (p_next0),
      .out_near1 (p_near1),
      .out_next1 (p_next1),
      .out_fx    (p_fx),
      .out_fy    (p_fy),
      .out_dest  (p_dest)
   );

   bpab_hlerp #(.FRAC_BITS(FRAC_BITS)) u_hlerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_near0  (p_near0),
      .in_next0  (p_next0),
      .in_near1  (p_near1),
      .in_next1  (p_next1),
      .in_fx     (p_fx),
      .in_fy     (p_fy),
      .in_dest   (p_dest),
      .out_valid (h_valid),
      .out_ready (h_ready),
      .out_row0  (h_row0),
      .out_row1  (h_row1),
      .out_fy    (h_fy),
      .out_dest  (h_dest)
   );

   bpab_vlerp #(.FRAC_BITS(FRAC_BITS)) u_vlerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_valid),
      .in_ready  (h_ready),
      .in_row0   (h_row0),
      .in_row1   (h_row1),
      .in_fy     (h_fy),
      .in_dest   (h_dest),
      .out_valid (v_valid),
      .out_ready (v_ready),
      .out_src   (v_src),
      .out_dest  (v_dest)
   );

   bpab_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v_valid),
      .in_ready (v_ready),
      .in_src   (v_src),
      .in_dest  (v_dest),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("pipeline stalls with the response side ready");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(v_valid))
      else $error("response word appeared without a vertical stage word");

   a_vlerp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(v_valid) |-> $past(h_valid))
      else $error("vertical stage word appeared without a horizontal word");

   a_hlerp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(h_valid) |-> $past(p_valid))
      else $error("horizontal stage word appeared without an input word");
`endif

endmodule
`default_nettype wire

/* tb/sv/bilinear_pixel_alpha_blend_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_pixel_alpha_blend_tb
// Streams pixel words through the blend pipeline and checks every blended
// word. A short table of corner cases comes first, then random words, with
// random stalls on both channels. Each result is compared against its row's
// typed value, if any, else an in-bench bilinear sample and alpha merge model.
// ----------------------------------------------------------------------------
module bilinear_pixel_alpha_blend_tb;
   import bpab_pkg::*;

   localparam int DIR_ROWS   = 18;
   localparam int RAND_WORDS = 1300;
   localparam int CALM_TAIL  = 200;
   localparam int QUIET_MAX  = 5000;
   localparam int ONE        = 1 << FRAC_BITS_DEF;

   typedef struct packed {
      logic [23:0] top_left_rgb;
      logic [23:0] top_right_rgb;
      logic [23:0] bottom_left_rgb;
      logic [23:0] bottom_right_rgb;
      logic [31:0] alpha_quad;
      logic [7:0]  frac_x;
      logic [7:0]  frac_y;
      logic        right_valid;
      logic        below_valid;
      logic [23:0] dest_rgb;
   } pixel_word_type;

   typedef struct packed {
      logic [7:0] out_channel_one;
      logic [7:0] out_channel_two;
      logic [7:0] out_channel_three;
      logic [7:0] blend_alpha;
   } blend_word_type;

   typedef struct packed {
      pixel_word_type pixel;
      logic           typed;
      blend_word_type blend;
   } corner_row_type;

   logic clock = 1'b0;
   logic reset;
   logic bursts_on = 1'b1;
   int   stall_left = 0;
   int   quiet_cycles = 0;
   int   mismatches = 0;

   blend_word_type pending_blends[$];
   blend_word_type oldest_blend;

   bpab_req_if req_bus ();
   bpab_rsp_if rsp_bus ();

   bilinear_pixel_alpha_blend dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   corner_row_type corner_rows [DIR_ROWS] = '{
      '{'{24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
          8'h00, 8'h00, 1'b1, 1'b1, 24'h000000}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h00000000,
          8'h00, 8'h00, 1'b1, 1'b1, 24'h000000}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h00}},
      '{'{24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'hFFFFFFFF,
          8'h00, 8'h00, 1'b1, 1'b1, 24'hABCDEF}, 1'b1, '{8'hEF, 8'hCD, 8'hAB, 8'hFF}},
      '{'{24'h000000, 24'h123456, 24'h000000, 24'h000000, 32'h00000000,
          8'hFF, 8'h00, 1'b1, 1'b1, 24'h000000}, 1'b1, '{8'h56, 8'h34, 8'h12, 8'h00}},
      '{'{24'h000000, 24'h123456, 24'h000000, 24'h000000, 32'h00000000,
          8'hFF, 8'h00, 1'b0, 1'b1, 24'h5A5A5A}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{24'h000000, 24'h000000, 24'h654321, 24'h000000, 32'h00000000,
          8'h00, 8'hC8, 1'b1, 1'b1, 24'h000000}, 1'b1, '{8'h21, 8'h43, 8'h65, 8'h00}},
      '{'{24'h000000, 24'h000000, 24'h654321, 24'h000000, 32'h00000000,
          8'h00, 8'hC8, 1'b1, 1'b0, 24'h000000}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 32'h00000000,
          8'h80, 8'h80, 1'b1, 1'b1, 24'h000000}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h00}},
      '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF,
          8'hFF, 8'hFF, 1'b1, 1'b1, 24'hFFFFFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      '{'{24'h7F80FF, 24'h7F80FF, 24'h7F80FF, 24'h7F80FF, 32'h00000000,
          8'h4D, 8'h21, 1'b1, 1'b1, 24'hFFFFFF}, 1'b1, '{8'hFF, 8'h80, 8'h7F, 8'h00}},
      '{'{24'h102030, 24'hF0E0D0, 24'h0A0B0C, 24'hC0B0A0, 32'h80FF4000,
          8'h81, 8'h81, 1'b1, 1'b1, 24'h3C5A78}, 1'b0, '0},
      '{'{24'h102030, 24'hF0E0D0, 24'h0A0B0C, 24'hC0B0A0, 32'h80FF4000,
          8'h7F, 8'h7F, 1'b1, 1'b1, 24'h3C5A78}, 1'b0, '0},
      '{'{24'hFF00FF, 24'h00FF00, 24'h55AA55, 24'hAA55AA, 32'h11EE22DD,
          8'h40, 8'h40, 1'b0, 1'b0, 24'h808080}, 1'b0, '0},
      '{'{24'hFF00FF, 24'h00FF00, 24'h55AA55, 24'hAA55AA, 32'h11EE22DD,
          8'h55, 8'h2A, 1'b0, 1'b1, 24'h808080}, 1'b0, '0},
      '{'{24'hFF00FF, 24'h00FF00, 24'h55AA55, 24'hAA55AA, 32'h11EE22DD,
          8'h2A, 8'h55, 1'b1, 1'b0, 24'h808080}, 1'b0, '0},
      '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h80808080,
          8'h33, 8'h66, 1'b1, 1'b1, 24'h000000}, 1'b0, '0},
      '{'{24'h00FF80, 24'hFF0080, 24'h80FF00, 24'h0080FF, 32'hFF0000FF,
          8'h01, 8'hFE, 1'b1, 1'b1, 24'h01FE7F}, 1'b0, '0},
      '{'{24'h204060, 24'hE0C0A0, 24'h9F5F1F, 24'h3070B0, 32'h00FF00FF,
          8'h40, 8'h40, 1'b1, 1'b1, 24'hFF00FF}, 1'b0, '0}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] sample_lane(input logic [7:0] tl, tr, bl, br,
                                              input logic rv, bv, input int fx, fy);
      int top_row;
      int bot_row;
      int v;
      if (!rv) begin
         tr = tl;
         br = bl;
      end
      if (!bv) begin
         bl = tl;
         br = tr;
      end
      top_row = (int'(tl) << FRAC_BITS_DEF) + fx * (int'(tr) - int'(tl));
      bot_row = (int'(bl) << FRAC_BITS_DEF) + fx * (int'(br) - int'(bl));
      v = top_row + fy * ((bot_row >>> FRAC_BITS_DEF) - (top_row >>> FRAC_BITS_DEF));
      if (v < 0)
         v = 0;
      v = v >>> FRAC_BITS_DEF;
      if (v > 255)
         v = 255;
      return v[7:0];
   endfunction

   function automatic blend_word_type bilinear_blend(input pixel_word_type p);
      int             fx;
      int             fy;
      int             src;
      int             dst;
      int             merged;
      int             c;
      logic [7:0]     alpha;
      dest_bytes_type merged_bytes;
      fx = (p.frac_x > ONE) ? ONE : int'(p.frac_x);
      fy = (p.frac_y > ONE) ? ONE : int'(p.frac_y);
      alpha = sample_lane(p.alpha_quad[7:0], p.alpha_quad[15:8], p.alpha_quad[23:16],
                          p.alpha_quad[31:24], p.right_valid, p.below_valid, fx, fy);
      for (c = 0; c < NUM_CH; c++) begin
         src = sample_lane(p.top_left_rgb[BYTE_W*c +: BYTE_W],
                           p.top_right_rgb[BYTE_W*c +: BYTE_W],
                           p.bottom_left_rgb[BYTE_W*c +: BYTE_W],
                           p.bottom_right_rgb[BYTE_W*c +: BYTE_W],
                           p.right_valid, p.below_valid, fx, fy);
         dst = p.dest_rgb[BYTE_W*c +: BYTE_W];
         merged = (dst - src) * int'(alpha) + ((src << 8) | dst);
         if (merged < 0)
            merged = 0;
         merged_bytes[c] = merged[15:8];
      end
      return '{merged_bytes[0], merged_bytes[1], merged_bytes[2], alpha};
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] rand_frac();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'(ONE);
         2: return 8'($urandom_range(ONE + 1, 255));
         default: return 8'($urandom_range(0, ONE));
      endcase
   endfunction

   task automatic send_pixel(input pixel_word_type p, input logic typed,
                             input blend_word_type typed_blend);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.top_left_rgb     <= p.top_left_rgb;
      req_bus.top_right_rgb    <= p.top_right_rgb;
      req_bus.bottom_left_rgb  <= p.bottom_left_rgb;
      req_bus.bottom_right_rgb <= p.bottom_right_rgb;
      req_bus.alpha_quad       <= p.alpha_quad;
      req_bus.frac_x           <= p.frac_x;
      req_bus.frac_y           <= p.frac_y;
      req_bus.right_valid      <= p.right_valid;
      req_bus.below_valid      <= p.below_valid;
      req_bus.dest_rgb         <= p.dest_rgb;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_blends.push_back(typed ? typed_blend : bilinear_blend(p));
   endtask

   task automatic check_byte(input string field, input logic [7:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (!bursts_on) begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 16);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_blends.size() == 0) begin
            $error("blended word arrived with none pending");
            mismatches++;
         end else begin
            oldest_blend = pending_blends.pop_front();
            check_byte("out_channel_one", oldest_blend.out_channel_one,
                       rsp_bus.out_channel_one);
            check_byte("out_channel_two", oldest_blend.out_channel_two,
                       rsp_bus.out_channel_two);
            check_byte("out_channel_three", oldest_blend.out_channel_three,
                       rsp_bus.out_channel_three);
            check_byte("blend_alpha", oldest_blend.blend_alpha, rsp_bus.blend_alpha);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int             i;
      pixel_word_type p;
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.top_left_rgb     <= '0;
      req_bus.top_right_rgb    <= '0;
      req_bus.bottom_left_rgb  <= '0;
      req_bus.bottom_right_rgb <= '0;
      req_bus.alpha_quad       <= '0;
      req_bus.frac_x           <= '0;
      req_bus.frac_y           <= '0;
      req_bus.right_valid      <= 1'b0;
      req_bus.below_valid      <= 1'b0;
      req_bus.dest_rgb         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         send_pixel(corner_rows[i].pixel, corner_rows[i].typed, corner_rows[i].blend);

      for (i = 0; i < RAND_WORDS; i++) begin
         bursts_on <= (i < RAND_WORDS - CALM_TAIL) && ((i / 250) % 3 != 2);
         // drain the pipeline once before resuming
         if (i == RAND_WORDS / 2) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending_blends.size() != 0)
               @(posedge clock);
         end
         p.top_left_rgb     = {rand_byte(), rand_byte(), rand_byte()};
         p.top_right_rgb    = {rand_byte(), rand_byte(), rand_byte()};
         p.bottom_left_rgb  = {rand_byte(), rand_byte(), rand_byte()};
         p.bottom_right_rgb = {rand_byte(), rand_byte(), rand_byte()};
         p.alpha_quad       = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
         p.frac_x           = rand_frac();
         p.frac_y           = rand_frac();
         p.right_valid      = 1'($urandom_range(0, 1));
         p.below_valid      = 1'($urandom_range(0, 1));
         p.dest_rgb         = {rand_byte(), rand_byte(), rand_byte()};
         send_pixel(p, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_blends.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
